>>> src/bayer_bilinear_demosaic_assert.svh
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_assert.svh
// Assertion macros shared by the demosaic checker.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define BBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BBD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

	localparam int unsigned PIX_W         = 8;     // raw sample and color width
	localparam int unsigned CFG_W         = 12;    // image_width / image_height
	localparam int unsigned ROW_W         = 12;    // row counters
	localparam int unsigned PEND_W        = CFG_W + 1;
	localparam int unsigned DEF_MAX_WIDTH = 2048;
	localparam int unsigned DIM_MAX       = 4095;
	localparam int unsigned FIFO_DEPTH    = 4;
	localparam int unsigned APB_AW        = 4;
	localparam int unsigned APB_DW        = 32;

	localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd1280;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd1024;
	localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;
	localparam logic [1:0]       RST_PHASE  = 2'd0;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PHASE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] raw_pixel;
	} sample_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_end;
	} rgb_t;

	// Per-request control that rides alongside the line memory access.
	typedef struct packed {
		logic emit;
		logic top_edge;
		logic bot_edge;
		logic left_edge;
		logic right_edge;
		logic row_par;
		logic col_par;
		logic frame_end;
	} pix_ctl_t;

	// One window column: two stored rows plus the incoming sample.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} column_t;

endpackage

>>> src/bbd_line_mem.sv
// ----------------------------------------------------------------------------
// bbd_line_mem
// Dual line store in one memory word; read-modify-write with forwarding.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
	parameter int unsigned MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_write,
	input  logic [$clog2(MAX_WIDTH)-1:0]       req_addr,
	input  logic [bbd_pkg::PIX_W-1:0]          req_pixel,
	output logic                               col_valid,
	output bbd_pkg::column_t                   col
);
	import bbd_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	typedef struct packed {
		logic [PIX_W-1:0] older;   // second-previous row
		logic [PIX_W-1:0] newer;   // previous row
	} line_word_t;

	line_word_t       mem [MAX_WIDTH];
	line_word_t       rd_q;
	line_word_t       fwd_data_q;
	logic             fwd_q;
	logic             v_s1;
	logic             wr_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] pix_s1;
	line_word_t       cur_s1;
	line_word_t       wb_s1;

	always_ff @(posedge clk) begin
		if (req_valid) begin
			rd_q <= mem[req_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && wr_s1) begin
			mem[addr_s1] <= wb_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			v_s1  <= req_valid;
			// same entry read while the previous write lands: take the new word
			fwd_q <= req_valid && v_s1 && wr_s1 && (req_addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			wr_s1   <= req_write;
			addr_s1 <= req_addr;
			pix_s1  <= req_pixel;
		end
		fwd_data_q <= wb_s1;
	end

	always_comb begin
		cur_s1       = fwd_q ? fwd_data_q : rd_q;
		wb_s1.older  = cur_s1.newer;
		wb_s1.newer  = pix_s1;
		col.top      = cur_s1.older;
		col.mid      = cur_s1.newer;
		col.bot      = pix_s1;
	end

	assign col_valid = v_s1;

endmodule

>>> src/bbd_window.sv
// ----------------------------------------------------------------------------
// bbd_window
// 3x3 window shift register and bilinear color reconstruction.
// ----------------------------------------------------------------------------
module bbd_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              col_valid,
	input  bbd_pkg::column_t  col,
	input  bbd_pkg::pix_ctl_t ctl_s1,
	output logic              res_valid,
	output bbd_pkg::rgb_t     res
);
	import bbd_pkg::*;

	logic [PIX_W-1:0] win_q [3][3];
	logic             emit_s2;
	pix_ctl_t         ctl_s2;

	logic [PIX_W-1:0] c, ul, up, ur, lf, rt, dl, dn, dr;
	logic [PIX_W+1:0] plus_sum, diag_sum;
	logic [PIX_W:0]   horiz_sum, vert_sum;
	logic [PIX_W-1:0] plus, diag, horiz, vert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else begin
			emit_s2 <= col_valid && ctl_s1.emit;
			if (col_valid) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= col.top;
				win_q[1][2] <= col.mid;
				win_q[2][2] <= col.bot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (col_valid) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Mirror about the border pixel, then average.
	always_comb begin
		c  = win_q[1][1];
		ul = win_q[0][0];
		up = win_q[0][1];
		ur = win_q[0][2];
		lf = win_q[1][0];
		rt = win_q[1][2];
		dl = win_q[2][0];
		dn = win_q[2][1];
		dr = win_q[2][2];
		if (ctl_s2.top_edge) begin
			up = dn; ul = dl; ur = dr;
		end
		if (ctl_s2.bot_edge) begin
			dn = up; dl = ul; dr = ur;
		end
		if (ctl_s2.left_edge) begin
			lf = rt; ul = ur; dl = dr;
		end
		if (ctl_s2.right_edge) begin
			rt = lf; ur = ul; dr = dl;
		end
		plus_sum  = (PIX_W+2)'(up) + (PIX_W+2)'(lf) + (PIX_W+2)'(rt) + (PIX_W+2)'(dn);
		diag_sum  = (PIX_W+2)'(ul) + (PIX_W+2)'(ur) + (PIX_W+2)'(dl) + (PIX_W+2)'(dr);
		horiz_sum = (PIX_W+1)'(lf) + (PIX_W+1)'(rt);
		vert_sum  = (PIX_W+1)'(up) + (PIX_W+1)'(dn);
		plus      = plus_sum[PIX_W+1:2];
		diag      = diag_sum[PIX_W+1:2];
		horiz     = horiz_sum[PIX_W:1];
		vert      = vert_sum[PIX_W:1];
	end

	always_comb begin
		res.frame_end = ctl_s2.frame_end;
		unique case ({ctl_s2.row_par, ctl_s2.col_par})
			2'b00: begin
				res.red = c;     res.green = plus; res.blue = diag;
			end
			2'b11: begin
				res.red = diag;  res.green = plus; res.blue = c;
			end
			2'b01: begin
				res.red = horiz; res.green = c;    res.blue = vert;
			end
			default: begin
				res.red = vert;  res.green = c;    res.blue = horiz;
			end
		endcase
	end

	assign res_valid = emit_s2;

endmodule

>>> src/bbd_out_fifo.sv
// ----------------------------------------------------------------------------
// bbd_out_fifo
// Small result queue decoupling the pipeline from output backpressure.
// ----------------------------------------------------------------------------
module bbd_out_fifo (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	input  bbd_pkg::rgb_t                                push_data,
	input  logic                                         pop,
	output logic                                         head_valid,
	output bbd_pkg::rgb_t                                head,
	output logic [$clog2(bbd_pkg::FIFO_DEPTH+1)-1:0]     count
);
	import bbd_pkg::*;

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	rgb_t          entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

endmodule

>>> src/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic: streaming 3x3 bilinear Bayer demosaic, 8-bit RGB.
// Throughput: one request per clock while sample_ready is high; the line memory does one read-modify-write per cycle.
// Path: a result is registered in the line memory, then in the window, then in the output queue
// before it shows at rgb (each result trails its raw pixel by one row plus one pixel).
// Reset: counters, pipeline valids, window and queue clear; registers take defaults.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic #(
	parameter int unsigned MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// raw sample / flush requests
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  bbd_pkg::sample_t             sample,
	// reconstructed pixels
	output logic                         rgb_valid,
	input  logic                         rgb_ready,
	output bbd_pkg::rgb_t                rgb,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbd_pkg::APB_AW-1:0]   paddr,
	input  logic [bbd_pkg::APB_DW-1:0]   pwdata,
	output logic [bbd_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import bbd_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned CMP_W = (COL_W > CFG_W) ? COL_W : CFG_W;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [CFG_W-1:0] WIDTH_MAX =
		(MAX_WIDTH > DIM_MAX) ? CFG_W'(DIM_MAX) : CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(DIM_MAX);

	// ---------------------------------------------------------------- registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [1:0]       phase_q;
	logic             cfg_wr;
	logic             geom_wr;
	reg_idx_t         reg_idx;
	logic [CFG_W-1:0] wdim;
	logic [CFG_W-1:0] width_clamped;
	logic [CFG_W-1:0] height_clamped;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wdim    = pwdata[CFG_W-1:0];

	always_comb begin
		width_clamped  = (wdim < MIN_DIM) ? MIN_DIM : ((wdim > WIDTH_MAX) ? WIDTH_MAX : wdim);
		height_clamped = (wdim < MIN_DIM) ? MIN_DIM : ((wdim > HEIGHT_MAX) ? HEIGHT_MAX : wdim);
		geom_wr        = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			phase_q  <= RST_PHASE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= width_clamped;
				REG_HEIGHT: height_q <= height_clamped;
				REG_PHASE:  phase_q  <= pwdata[1:0];
				default: ;  // writes outside the map are dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_PHASE:  prdata = APB_DW'(phase_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- positions
	// in_*  : raster position of the next raw sample
	// out_* : raster position of the next pixel to emit
	// pend_q: samples taken but not emitted; saturates at width + 1
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [PEND_W-1:0] pend_q;

	logic in_last_col, in_last_row, out_last_col, out_last_row;
	logic in_origin, pend_full, pend_zero;
	logic accept, is_flush, flush_act, act, emit;
	logic [COL_W-1:0]  next_out_col;
	logic [COL_W-1:0]  mem_addr;
	logic [PIX_W-1:0]  mem_pixel;
	pix_ctl_t          ctl_s0;
	pix_ctl_t          ctl_s1;

	always_comb begin
		in_last_col  = (CMP_W'(in_col_q) == CMP_W'(width_q) - CMP_W'(1));
		out_last_col = (CMP_W'(out_col_q) == CMP_W'(width_q) - CMP_W'(1));
		in_last_row  = (in_row_q == height_q - CFG_W'(1));
		out_last_row = (out_row_q == height_q - CFG_W'(1));
		in_origin    = (in_col_q == '0) && (in_row_q == '0);
		pend_zero    = (pend_q == '0);
		pend_full    = (pend_q == PEND_W'(width_q) + PEND_W'(1));

		accept       = sample_valid && sample_ready;
		is_flush     = (sample.mode == MODE_FLUSH);
		// a flush only drains the tail of a frame before the next one starts
		flush_act    = in_origin && !pend_zero;
		act          = accept && (!is_flush || flush_act);
		emit         = accept && (is_flush ? flush_act : pend_full);

		next_out_col = out_last_col ? '0 : out_col_q + COL_W'(1);
		mem_addr     = is_flush ? next_out_col : in_col_q;
		mem_pixel    = is_flush ? '0 : sample.raw_pixel;

		ctl_s0.emit       = emit;
		ctl_s0.top_edge   = (out_row_q == '0);
		ctl_s0.bot_edge   = out_last_row;
		ctl_s0.left_edge  = (out_col_q == '0);
		ctl_s0.right_edge = out_last_col;
		ctl_s0.row_par    = out_row_q[0] ^ phase_q[1];
		ctl_s0.col_par    = out_col_q[0] ^ phase_q[0];
		ctl_s0.frame_end  = out_last_row && out_last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (geom_wr) begin
			// new geometry restarts the raster counters and drops pending samples
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (accept) begin
			if (!is_flush) begin
				in_col_q <= in_last_col ? '0 : in_col_q + COL_W'(1);
				if (in_last_col) begin
					in_row_q <= in_last_row ? '0 : in_row_q + ROW_W'(1);
				end
				if (!pend_full) begin
					pend_q <= pend_q + PEND_W'(1);
				end
			end else if (flush_act) begin
				pend_q <= pend_q - PEND_W'(1);
			end
			if (emit) begin
				out_col_q <= next_out_col;
				if (out_last_col) begin
					out_row_q <= out_last_row ? '0 : out_row_q + ROW_W'(1);
				end
			end
		end
	end

	// control follows the memory read into stage 1
	always_ff @(posedge clk) begin
		if (act) begin
			ctl_s1 <= ctl_s0;
		end
	end

	// ---------------------------------------------------------------- datapath
	logic          col_valid;
	column_t       col;
	logic          res_valid;
	rgb_t          res;
	logic [CNT_W-1:0] fifo_count;
	logic          emit_s1;
	logic [CNT_W:0] committed;

	bbd_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (act),
		.req_write (!is_flush),
		.req_addr  (mem_addr),
		.req_pixel (mem_pixel),
		.col_valid (col_valid),
		.col       (col)
	);

	bbd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col       (col),
		.ctl_s1    (ctl_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bbd_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (rgb_valid && rgb_ready),
		.head_valid (rgb_valid),
		.head       (rgb),
		.count      (fifo_count)
	);

	// Credit check: queue entries plus results still in the pipe must leave a
	// slot for whatever the next request may release.
	assign emit_s1   = col_valid && ctl_s1.emit;
	assign committed = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(emit_s1) + (CNT_W+1)'(res_valid);
	assign sample_ready = (committed < (CNT_W+1)'(FIFO_DEPTH));

endmodule

>>> src/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks for the demosaic, bound to the top level.
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_assert.svh"

module bbd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       sample_valid,
	input logic                       sample_ready,
	input logic                       rgb_valid,
	input logic                       rgb_ready,
	input bbd_pkg::rgb_t              rgb,
	input logic                       pready
);
	import bbd_pkg::*;

	// a stalled result is held
	`BBD_ASSERT(a_rgb_hold, rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb), "rgb changed under stall")

	// the queue is empty from the first clock of reset on
	`BBD_ASSERT_RST(a_rst_empty, !arst_n |=> !rgb_valid, "rgb_valid high in reset")

	// a result reaching an empty output was released by a request through the line memory, window and queue registers
	`BBD_ASSERT(a_rgb_cause, $rose(rgb_valid) |-> $past(sample_valid && sample_ready, 3), "result without request")

	// the register port never inserts wait states
	`BBD_ASSERT(a_pready, pready, "pready low")

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (.*);
